@@ rtl/sfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the sync-framed Fletcher packet checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned MaxPacketBytesDef = 1024;
  localparam int unsigned PacketLenW        = 11;
  localparam int unsigned CheckW            = 16;
  localparam int unsigned CfgIdxW           = 1;

  localparam logic [7:0] SyncFirstRst  = 8'd117;
  localparam logic [7:0] SyncSecondRst = 8'd101;

  localparam logic [CfgIdxW-1:0] RegSyncFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSyncSecond = 1'b1;

  typedef enum logic [1:0] {
    VerdictGood     = 2'd0,
    VerdictMismatch = 2'd1,
    VerdictShort    = 2'd2,
    VerdictLong     = 2'd3
  } verdict_e;

  typedef struct packed {
    verdict_e              verdict;
    logic [PacketLenW-1:0] packet_length;
    logic [CheckW-1:0]     computed_check;
    logic [CheckW-1:0]     received_check;
  } result_t;

endpackage

@@ rtl/sync_framed_fletcher_checker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_fletcher_checker_unit
// Splits a byte stream into sync-framed packets and checks the Fletcher-style
// checksum (sums modulo 256) carried in the last two bytes of each packet.
//
//   Channel | Direction | Handshake                 | Beat
//   in      | input     | in_valid_i / in_stall_o   | data_byte_i
//   out     | output    | out_valid_o / out_stall_i | verdict, length, checks
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One input beat is taken every cycle while in_stall_o is low; the framing
// state updates in the cycle of acceptance; a closing verdict is registered.
// Two result registers (output and skid) let input continue while a verdict
// waits; in_stall_o rises only when both are full.
// Reset is asynchronous and active low; the sync bytes return to 'u' and 'e'.
// ----------------------------------------------------------------------------
module sync_framed_fletcher_checker_unit #(
  parameter int unsigned MAX_PACKET_BYTES = sfc_pkg::MaxPacketBytesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output sfc_pkg::verdict_e                 verdict_o,
  output logic [sfc_pkg::PacketLenW-1:0]    packet_length_o,
  output logic [sfc_pkg::CheckW-1:0]        computed_check_o,
  output logic [sfc_pkg::CheckW-1:0]        received_check_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);
  import sfc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES + 2);
  localparam int unsigned LenW = (CntW > PacketLenW) ? CntW : PacketLenW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PACKET_BYTES);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_PACKET_BYTES + 1);

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [7:0]      sum_a;
    logic [7:0]      sum_b;
    logic [7:0]      last;
    logic [7:0]      second_last;
  } pkt_state_t;

  function automatic pkt_state_t take_byte(pkt_state_t s, logic [7:0] b);
    pkt_state_t r;
    r = s;
    if (s.cnt >= CntW'(2)) begin
      r.sum_a = s.sum_a + s.second_last;
      r.sum_b = s.sum_b + r.sum_a;
    end
    r.second_last = s.last;
    r.last        = b;
    if (s.cnt < CntSat) begin
      r.cnt = s.cnt + CntW'(1);
    end
    return r;
  endfunction

  logic [7:0] sync_first_q, sync_second_q;
  logic       pending_q, pending_d;
  pkt_state_t st_q, st_d;

  logic       in_acc, close, pop;
  result_t    res;
  logic       short_pkt, long_pkt;
  logic [CntW-1:0] len_cnt;
  logic [LenW-1:0] len_ext;

  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegSyncFirst:  sync_first_q  <= cfg_data_i;
        RegSyncSecond: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign close  = pending_q && (data_byte_i == sync_second_q) && (st_q.cnt != '0);

  always_comb begin
    st_d      = st_q;
    pending_d = pending_q;
    if (pending_q) begin
      if (close) begin
        st_d = '0;
      end
      st_d = take_byte(st_d, sync_first_q);
    end
    if (data_byte_i == sync_first_q) begin
      pending_d = 1'b1;
    end else begin
      pending_d = 1'b0;
      st_d      = take_byte(st_d, data_byte_i);
    end
  end

  always_comb begin
    short_pkt = st_q.cnt < CntW'(2);
    long_pkt  = st_q.cnt > CntMax;
    len_cnt   = long_pkt ? CntMax : st_q.cnt;
    len_ext   = LenW'(len_cnt);
    res.packet_length  = len_ext[PacketLenW-1:0];
    res.computed_check = short_pkt ? '0 : {st_q.sum_a, st_q.sum_b};
    res.received_check = short_pkt ? '0 : {st_q.second_last, st_q.last};
    priority if (short_pkt) begin
      res.verdict = VerdictShort;
    end else if (long_pkt) begin
      res.verdict = VerdictLong;
    end else if (res.computed_check != res.received_check) begin
      res.verdict = VerdictMismatch;
    end else begin
      res.verdict = VerdictGood;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      st_q      <= '0;
    end else if (in_acc) begin
      pending_q <= pending_d;
      st_q      <= st_d;
    end
  end

  // The output register takes a new verdict when empty or drained this cycle;
  // otherwise the verdict parks in the skid register.
  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc && close) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc && close) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o       = skid_valid_q;
  assign out_valid_o      = out_valid_q;
  assign verdict_o        = out_q.verdict;
  assign packet_length_o  = out_q.packet_length;
  assign computed_check_o = out_q.computed_check;
  assign received_check_o = out_q.received_check;

endmodule

@@ rtl/sfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks of the sync-framed Fletcher packet checker.
// ----------------------------------------------------------------------------
module sfc_checker #(
  parameter int unsigned MAX_PACKET_BYTES = sfc_pkg::MaxPacketBytesDef
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input sfc_pkg::verdict_e              verdict_o,
  input logic [sfc_pkg::PacketLenW-1:0] packet_length_o,
  input logic [sfc_pkg::CheckW-1:0]     computed_check_o,
  input logic [sfc_pkg::CheckW-1:0]     received_check_o
);
  import sfc_pkg::*;

  // Input backpressure only appears when a verdict is already waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o) &&
      $stable(packet_length_o) && $stable(computed_check_o) &&
      $stable(received_check_o))
    else $error("stalled verdict beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VerdictShort |->
      packet_length_o < PacketLenW'(2) && computed_check_o == '0 &&
      received_check_o == '0)
    else $error("short packet verdict with bad fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o == VerdictGood || verdict_o == VerdictMismatch) |->
      (verdict_o == VerdictGood) == (computed_check_o == received_check_o))
    else $error("checksum verdict disagrees with reported checks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == VerdictLong |->
      packet_length_o == PacketLenW'(MAX_PACKET_BYTES))
    else $error("long packet verdict without saturated length");

endmodule

bind sync_framed_fletcher_checker_unit sfc_checker #(
  .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
) u_sfc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .verdict_o        (verdict_o),
  .packet_length_o  (packet_length_o),
  .computed_check_o (computed_check_o),
  .received_check_o (received_check_o)
);
